### rtl/replication_peer_progress_table_macros.svh
// Assertion shorthands shared by the progress table RTL.
`ifndef REPLICATION_PEER_PROGRESS_TABLE_MACROS_SVH
`define REPLICATION_PEER_PROGRESS_TABLE_MACROS_SVH

// Plain property, checked at every clock edge out of reset.
`define RPPT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Same-cycle implication.
`define RPPT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RPPT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/rppt_pkg.sv
package rppt_pkg;

    localparam int IDX_W = 64;

    typedef enum logic [3:0] {
        REQ_LEADER_RESET   = 4'd0,
        REQ_APPEND_OK      = 4'd1,
        REQ_APPEND_FAIL    = 4'd2,
        REQ_SNAP_MARK      = 4'd3,
        REQ_MARK_INFLIGHT  = 4'd4,
        REQ_CLEAR_INFLIGHT = 4'd5,
        REQ_SET_NEXT       = 4'd6,
        REQ_SET_MATCH      = 4'd7,
        REQ_READ           = 4'd8
    } t_req;

    typedef enum logic [0:0] {
        CFG_MEMBER_MASK = 1'b0,
        CFG_SELF_SLOT   = 1'b1
    } t_cfg_idx;

    // One table row; next index sits in the low bits.
    typedef struct packed {
        logic [IDX_W-1:0] inflight;
        logic [IDX_W-1:0] wmark;
        logic [IDX_W-1:0] match_idx;
        logic [IDX_W-1:0] next_idx;
    } t_row;

    // Request as held for the whole operation.
    typedef struct packed {
        t_req             req;
        logic [IDX_W-1:0] iv;
        logic [IDX_W-1:0] sv;
        logic             ok;        // peer slot exists
        logic             lead_hit;  // peer gets next = last + 1 on leader reset
    } t_job;

    typedef struct packed {
        t_row             row;
        logic             accepted;
        logic             match_at_least;
        logic [IDX_W-1:0] iv_p1;
    } t_calc_res;

endpackage

### rtl/replication_peer_progress_table.sv
// Leader-side progress table for up to PEER_SLOTS replication peers. Each
// request names an operation and a peer slot; the block updates that peer's
// next, match, snapshot watermark and in-flight snapshot entries and returns
// them together with an accepted flag and a match-at-least-index compare.
// An ordinary request runs in order: the accepting edge starts the
// synchronous row read, the adds and compares on the row are then registered,
// and last the result is resolved, written back to the row and loaded into
// the output register. A leader reset instead rewrites every row through the
// single write port, one row a cycle, before its result is loaded. One request
// is in work at a time; a new request is taken while a finished result still
// waits in the output register, but the next result holds in the block until
// that register drains. Rows never written since reset read as zero through
// per-row valid bits, so there is no clearing pass after reset. Configuration
// (member mask, own slot) is written through a separate port that is always
// ready; write it only while the block idles. Slots at or beyond PEER_SLOTS
// read as zero and are never written.
`include "replication_peer_progress_table_macros.svh"

module replication_peer_progress_table import rppt_pkg::*; #(
    parameter int PEER_SLOTS = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // request channel
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // [63:0] index_value, [127:64] second_value
    input  logic [6:0]   s_axis_tuser,   // [3:0] req_type, [6:4] peer
    // result channel
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [255:0] m_axis_tdata,   // next_out, match_out, watermark_out, inflight_out
    output logic [1:0]   m_axis_tuser,   // [0] accepted, [1] match_at_least
    // configuration writes
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [0:0]   i_cfg_index,
    input  logic [7:0]   i_cfg_data
);

    localparam int AW = $clog2(PEER_SLOTS);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_WIPE = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    t_job          r_job, n_job;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_wipe_cnt, n_wipe_cnt;
    logic [7:0]    r_member_mask;
    logic [2:0]    r_self_slot;
    logic          r_out_valid, n_out_valid;
    t_row          r_out_row;
    logic [1:0]    r_out_user;

    logic          w_accept;
    logic [2:0]    w_peer;
    logic          w_peer_ok;
    logic          w_fire;
    logic          w_wipe_last;
    logic [7:0]    w_mask_sh;
    logic          w_wipe_hit;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_row          w_wdata;
    t_row          w_rdata;
    t_calc_res     w_res;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_member_mask <= '0;
            r_self_slot   <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MEMBER_MASK: r_member_mask <= i_cfg_data;
                CFG_SELF_SLOT:   r_self_slot   <= i_cfg_data[2:0];
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Request capture: start the row read on the accepting edge
    // ---------------------------------------------------------------
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_peer        = s_axis_tuser[6:4];
    assign w_peer_ok     = 32'(w_peer) < 32'(PEER_SLOTS);

    always_comb begin
        n_job          = r_job;
        if (w_accept) begin
            n_job.req      = t_req'(s_axis_tuser[3:0]);
            n_job.iv       = s_axis_tdata[63:0];
            n_job.sv       = s_axis_tdata[127:64];
            n_job.ok       = w_peer_ok;
            n_job.lead_hit = w_peer_ok && r_member_mask[w_peer] && (w_peer != r_self_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        if (w_accept) begin
            r_addr <= AW'(w_peer);
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    // Result leaves only when the output register is free or draining.
    assign w_fire      = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);
    assign w_wipe_last = (r_wipe_cnt == AW'(PEER_SLOTS - 1));

    always_comb begin
        n_state    = r_state;
        n_wipe_cnt = r_wipe_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = (r_job.req == REQ_LEADER_RESET) ? ST_WIPE : ST_DONE;
            end
            ST_WIPE: begin
                if (w_wipe_last) begin
                    n_wipe_cnt = '0;
                    n_state    = ST_DONE;
                end else begin
                    n_wipe_cnt = r_wipe_cnt + AW'(1);
                end
            end
            ST_DONE: begin
                if (w_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_wipe_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_wipe_cnt <= n_wipe_cnt;
        end
    end

    // ---------------------------------------------------------------
    // Table write port: leader-reset sweep or single-row write back
    // ---------------------------------------------------------------
    // Only the low eight slots can be members; higher slots shift out to zero.
    assign w_mask_sh  = r_member_mask >> r_wipe_cnt;
    assign w_wipe_hit = w_mask_sh[0] && (32'(r_wipe_cnt) != 32'(r_self_slot));

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = w_res.row;
        if (r_state == ST_WIPE) begin
            w_we             = 1'b1;
            w_waddr          = r_wipe_cnt;
            w_wdata          = '0;
            w_wdata.next_idx = w_wipe_hit ? w_res.iv_p1 : '0;
        end else if (w_fire && r_job.ok && r_job.req != REQ_LEADER_RESET) begin
            w_we = 1'b1;
        end
    end

    rppt_mem #(
        .DEPTH (PEER_SLOTS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (w_accept),
        .i_raddr (AW'(w_peer)),
        .o_rdata (w_rdata),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata)
    );

    rppt_calc u_calc (
        .i_clk  (i_clk),
        .i_load (r_state == ST_LOAD),
        .i_job  (r_job),
        .i_old  (w_rdata),
        .o_res  (w_res)
    );

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_fire) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_row  <= w_res.row;
            r_out_user <= {w_res.match_at_least, w_res.accepted};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_row;
    assign m_axis_tuser  = r_out_user;

    `RPPT_ASSERT_NXT(a_accept_load, i_clk, i_rst_n, w_accept, r_state == ST_LOAD, "accepted request did not start a row read")
    `RPPT_ASSERT_IMP(a_idle_no_write, i_clk, i_rst_n, r_state == ST_IDLE, !w_we, "table written while idle")
    `RPPT_ASSERT_IMP(a_write_ok, i_clk, i_rst_n, (r_state == ST_DONE) && w_we, r_job.ok, "write back to a missing slot")
    `RPPT_ASSERT_NXT(a_wipe_wrap, i_clk, i_rst_n, (r_state == ST_WIPE) && w_wipe_last, (r_wipe_cnt == '0) && (r_state == ST_DONE), "sweep did not end cleanly")

endmodule

### rtl/rppt_mem.sv
`include "replication_peer_progress_table_macros.svh"

module rppt_mem import rppt_pkg::*; #(
    parameter int DEPTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_row          o_rdata,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_row          i_wdata
);

    t_row             r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    t_row             r_rdata;
    logic             r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    // Rows never written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvalid <= r_valid[i_raddr];
            end
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

    `RPPT_ASSERT(a_no_collide, i_clk, i_rst_n, !(i_re && i_we), "read and write in one cycle")
    `RPPT_ASSERT_IMP(a_waddr_range, i_clk, i_rst_n, i_we, 32'(i_waddr) < 32'(DEPTH), "write address beyond depth")
    `RPPT_ASSERT_NXT(a_valid_set, i_clk, i_rst_n, i_we, r_valid[$past(i_waddr)], "written row not marked valid")

endmodule

### rtl/rppt_calc.sv
module rppt_calc import rppt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_load,
    input  t_job      i_job,
    input  t_row      i_old,
    output t_calc_res o_res
);

    t_row             r_old;
    logic [IDX_W-1:0] r_sum, r_sum_p1, r_n1, r_iv_p1, r_nx_m1, r_mt_p1;
    logic             r_nx_gt1, r_mt_ge_iv, r_iv_zero, r_fl_zero, r_fl_eq_iv;

    // First half: independent adds and compares on the row just read.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_old      <= i_old;
            r_sum      <= i_job.iv + i_job.sv;
            r_sum_p1   <= i_job.iv + i_job.sv + IDX_W'(1);
            r_n1       <= (i_job.iv < i_job.sv) ? i_job.iv + IDX_W'(1)
                                                : i_job.sv + IDX_W'(1);
            r_iv_p1    <= i_job.iv + IDX_W'(1);
            r_nx_m1    <= i_old.next_idx - IDX_W'(1);
            r_mt_p1    <= i_old.match_idx + IDX_W'(1);
            r_nx_gt1   <= i_old.next_idx > IDX_W'(1);
            r_mt_ge_iv <= i_old.match_idx >= i_job.iv;
            r_iv_zero  <= i_job.iv == '0;
            r_fl_zero  <= i_old.inflight == '0;
            r_fl_eq_iv <= i_old.inflight == i_job.iv;
        end
    end

    // Second half: parallel compares, then selection only.
    logic w_up, w_sum_ge_iv, w_dec, w_ga, w_gb, w_wm_gt, w_nx_gt;

    assign w_up        = r_sum > r_old.match_idx;
    assign w_sum_ge_iv = r_sum >= i_job.iv;
    assign w_dec       = (r_n1 >= r_old.next_idx) && r_nx_gt1;
    assign w_ga        = r_n1 > r_mt_p1;
    assign w_gb        = r_nx_m1 > r_mt_p1;
    assign w_wm_gt     = r_old.wmark > i_job.iv;
    assign w_nx_gt     = r_old.next_idx > r_iv_p1;

    always_comb begin
        t_row row;
        logic acc;
        logic mal;
        row = r_old;
        acc = 1'b1;
        mal = r_mt_ge_iv;
        unique case (i_job.req)
            REQ_LEADER_RESET: begin
                row          = '0;
                row.next_idx = i_job.lead_hit ? r_iv_p1 : '0;
                mal          = r_iv_zero;
            end
            REQ_APPEND_OK: begin
                row.match_idx = w_up ? r_sum : r_old.match_idx;
                row.next_idx  = w_up ? r_sum_p1 : r_mt_p1;
                mal           = w_up ? w_sum_ge_iv : r_mt_ge_iv;
            end
            REQ_APPEND_FAIL: begin
                if (w_dec ? w_gb : w_ga) begin
                    row.next_idx = w_dec ? r_nx_m1 : r_n1;
                end else begin
                    row.next_idx = r_mt_p1;
                end
            end
            REQ_SNAP_MARK: begin
                row.wmark     = w_wm_gt ? r_old.wmark : i_job.iv;
                row.match_idx = r_mt_ge_iv ? r_old.match_idx : i_job.iv;
                row.next_idx  = w_nx_gt ? r_old.next_idx : r_iv_p1;
                mal           = 1'b1;
            end
            REQ_MARK_INFLIGHT: begin
                if (r_fl_zero) begin
                    row.inflight = i_job.iv;
                end else begin
                    acc = 1'b0;
                end
            end
            REQ_CLEAR_INFLIGHT: begin
                if (r_fl_eq_iv) begin
                    row.inflight = '0;
                end
            end
            REQ_SET_NEXT: begin
                row.next_idx = i_job.iv;
            end
            REQ_SET_MATCH: begin
                row.match_idx = i_job.iv;
                mal           = 1'b1;
            end
            default: begin
                // read and unused codes: no change
            end
        endcase
        // A slot beyond the table reads as zero and has nothing pending.
        if (!i_job.ok && i_job.req != REQ_LEADER_RESET) begin
            row = '0;
            acc = 1'b1;
            mal = r_iv_zero;
        end
        o_res.row            = row;
        o_res.accepted       = acc;
        o_res.match_at_least = mal;
        o_res.iv_p1          = r_iv_p1;
    end

endmodule
